/* rtl/mmh_pkg.sv */
// Shared constants and helpers for the 64-bit word hash block.
`timescale 1ns / 1ps

package mmh_pkg;

  localparam int unsigned MMH_COUNT_BITS = 16;
  localparam int unsigned MMH_WORD_W     = 64;
  localparam int unsigned MMH_HALF_W     = MMH_WORD_W / 2;
  localparam int unsigned MMH_MIX_SHIFT  = 47;
  localparam int unsigned MMH_BYTE_SHIFT = 3;  // word count times 8 bytes

  localparam logic [MMH_WORD_W-1:0] MMH_MIX_MUL    = 64'hc6a4_a793_5bd1_e995;
  localparam logic [MMH_WORD_W-1:0] MMH_SEED_RESET = 64'd12345;

  // x ^ (x >> 47)
  function automatic logic [MMH_WORD_W-1:0] mmh_xorshift(input logic [MMH_WORD_W-1:0] x);
    return x ^ (x >> MMH_MIX_SHIFT);
  endfunction

endpackage

/* rtl/murmur64a_word_hash.sv */
// A word keeps the block busy for three multiplies by M, plus the seed multiply for a
// first word; a last word adds the finalize multiply before its hash reaches the output
// register. A new word is taken only in the idle state, once the last one is through;
// the pace is set by the single 32x32 multiplier, three passes per 64-bit multiply; a
// stalled result holds the finalize step, and with it the input. Reset (rst_n low,
// synchronous): sequencer idle, no result pending, running hash zero, seed back to 12345.
`timescale 1ns / 1ps

module murmur64a_word_hash
  import mmh_pkg::*;
#(
  parameter int unsigned COUNT_BITS = MMH_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // word request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [MMH_WORD_W-1:0]  in_data_word,
  input  logic [COUNT_BITS-1:0]  in_message_words,
  input  logic                   in_first_word,
  input  logic                   in_last_word,
  // hash result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [MMH_WORD_W-1:0]  out_hash_value,
  // seed register write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [MMH_WORD_W-1:0]  cfg_hash_seed
);

  // One multiply by M is built from three 32x32 partial products:
  //   pass 0: lo(x) * lo(M)          -> full 64-bit product
  //   pass 1: lo(x) * hi(M)          -> low half added into the upper word
  //   pass 2: hi(x) * lo(M)          -> same, and the product is complete
  // hi(x)*hi(M) only lands above bit 63 and is dropped (mod 2^64).
  typedef enum logic [2:0] {
    ST_IDLE,   // wait for a word request
    ST_INIT,   // (count * 8) * M for the first word
    ST_K1,     // word * M
    ST_K2,     // xorshift(word * M) * M
    ST_H,      // (hash ^ k) * M
    ST_FIN     // xorshift(hash) * M, result goes out
  } state_t;

  localparam logic [1:0] PASS_LAST = 2'd2;

  state_t                  state_r,     state_nxt;
  logic [1:0]              pass_r,      pass_nxt;
  logic [MMH_WORD_W-1:0]   opnd_r,      opnd_nxt;    // multiplicand for the current multiply
  logic [MMH_WORD_W-1:0]   acc_r,       acc_nxt;     // partial-product accumulator
  logic [MMH_WORD_W-1:0]   word_r,      word_nxt;    // held message word
  logic                    last_r,      last_nxt;
  logic [MMH_WORD_W-1:0]   seed_r,      seed_nxt;
  logic [MMH_WORD_W-1:0]   hash_r,      hash_nxt;    // running (unfinalized) hash
  logic                    out_valid_r, out_valid_nxt;
  logic [MMH_WORD_W-1:0]   out_hash_r,  out_hash_nxt;

  logic [MMH_HALF_W-1:0]   mul_a;
  logic [MMH_HALF_W-1:0]   mul_b;
  logic [MMH_WORD_W-1:0]   mul_prod;
  logic [MMH_WORD_W-1:0]   mul_sum;
  logic                    mul_done;
  logic                    out_free;

  // Shared multiplier: pick the halves for this pass.
  assign mul_a    = (pass_r == PASS_LAST) ? opnd_r[MMH_WORD_W-1:MMH_HALF_W]
                                          : opnd_r[MMH_HALF_W-1:0];
  assign mul_b    = (pass_r == 2'd1) ? MMH_MIX_MUL[MMH_WORD_W-1:MMH_HALF_W]
                                     : MMH_MIX_MUL[MMH_HALF_W-1:0];
  assign mul_prod = MMH_WORD_W'(mul_a) * MMH_WORD_W'(mul_b);

  // Cross terms only touch the upper half of the accumulator.
  assign mul_sum  = (pass_r == 2'd0) ? mul_prod
                  : {acc_r[MMH_WORD_W-1:MMH_HALF_W] + mul_prod[MMH_HALF_W-1:0],
                     acc_r[MMH_HALF_W-1:0]};
  assign mul_done = (pass_r == PASS_LAST);

  // Output register can take a new hash when empty or being drained now.
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall       = (state_r != ST_IDLE);
  assign cfg_ready      = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    opnd_nxt      = opnd_r;
    acc_nxt       = acc_r;
    word_nxt      = word_r;
    last_nxt      = last_r;
    seed_nxt      = seed_r;
    hash_nxt      = hash_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          seed_nxt = cfg_hash_seed;
        end
        if (in_valid) begin
          word_nxt = in_data_word;
          last_nxt = in_last_word;
          pass_nxt = 2'd0;
          if (in_first_word) begin
            // count * 8 fits inside 64 bits for count widths up to 61 bits
            opnd_nxt  = MMH_WORD_W'(in_message_words) << MMH_BYTE_SHIFT;
            state_nxt = ST_INIT;
          end else begin
            opnd_nxt  = in_data_word;
            state_nxt = ST_K1;
          end
        end
      end

      ST_INIT, ST_K1, ST_K2, ST_H, ST_FIN: begin
        if (!mul_done) begin
          acc_nxt  = mul_sum;
          pass_nxt = pass_r + 2'd1;
        end else if (state_r != ST_FIN || out_free) begin
          acc_nxt  = mul_sum;
          pass_nxt = 2'd0;
          case (state_r)
            ST_INIT: begin
              hash_nxt  = seed_r ^ mul_sum;
              opnd_nxt  = word_r;
              state_nxt = ST_K1;
            end
            ST_K1: begin
              opnd_nxt  = mmh_xorshift(mul_sum);
              state_nxt = ST_K2;
            end
            ST_K2: begin
              opnd_nxt  = hash_r ^ mul_sum;
              state_nxt = ST_H;
            end
            ST_H: begin
              hash_nxt = mul_sum;
              if (last_r) begin
                opnd_nxt  = mmh_xorshift(mul_sum);
                state_nxt = ST_FIN;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
            default: begin
              // finalize: last xorshift and hand the hash to the output register
              out_hash_nxt  = mmh_xorshift(mul_sum);
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          endcase
        end
        // else: hold the finished product until the output register frees up
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= 2'd0;
      seed_r      <= MMH_SEED_RESET;
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      seed_r      <= seed_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // payload: no reset needed
    opnd_r     <= opnd_nxt;
    acc_r      <= acc_nxt;
    word_r     <= word_nxt;
    last_r     <= last_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule

/* rtl/mmh_checker.sv */
// Port-level assertions for the word hash block, bound to its top level.
`timescale 1ns / 1ps

module mmh_checker
  import mmh_pkg::*;
#(
  parameter int unsigned COUNT_BITS = MMH_COUNT_BITS
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [MMH_WORD_W-1:0] in_data_word,
  input logic [COUNT_BITS-1:0] in_message_words,
  input logic                  in_first_word,
  input logic                  in_last_word,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [MMH_WORD_W-1:0] out_hash_value,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [MMH_WORD_W-1:0] cfg_hash_seed
);

  // a request makes the block busy on the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took a request and did not go busy");

  // a new hash only appears right after a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("hash result appeared without work in progress");

  // seed writes are refused while a word is being hashed
  a_cfg_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !cfg_ready)
    else $error("seed write accepted while busy");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_hash_value)))
    else $error("stalled hash result changed or dropped");

endmodule

bind murmur64a_word_hash mmh_checker #(.COUNT_BITS(COUNT_BITS)) u_mmh_checker (.*);

/* bench/murmur64a_word_hash_test.sv */
// Self-checking testbench for the murmur64a_word_hash block.
`timescale 1ns / 1ps

module murmur64a_word_hash_test;
  import mmh_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 1300;
  localparam int unsigned HOLD_OFF_CYCLES = 400;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES   = 24;    // settle margin for a word still in the block
  localparam int unsigned STUCK_LIMIT     = 3000;  // idle cycles before giving up

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [MMH_WORD_W-1:0]     in_data_word = '0;
  logic [MMH_COUNT_BITS-1:0] in_message_words = '0;
  logic                      in_first_word = 1'b0;
  logic                      in_last_word = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [MMH_WORD_W-1:0]     out_hash_value;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [MMH_WORD_W-1:0]     cfg_hash_seed = '0;

  // Predictor state: seed register and the unfinalized running hash.
  logic [MMH_WORD_W-1:0] seed_model = MMH_SEED_RESET;
  logic [MMH_WORD_W-1:0] running_hash_model = '0;
  logic [MMH_WORD_W-1:0] expected_hashes [$];
  logic [MMH_WORD_W-1:0] oldest_hash;
  int unsigned           mismatch_count = 0;

  // Idling controls: quiet turns gaps off on one side; hold_request asks
  // the receiver for one long hold-off, which it counts out itself.
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned stuck_cycles = 0;

  murmur64a_word_hash i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_word     (in_data_word),
    .in_message_words (in_message_words),
    .in_first_word    (in_first_word),
    .in_last_word     (in_last_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hash_value   (out_hash_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_hash_seed    (cfg_hash_seed)
  );

  always #6 clk = ~clk;

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Data word: mostly full random, with zero, all ones and one-hot words mixed in.
  function automatic logic [MMH_WORD_W-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll == 2) return 64'd1 << $urandom_range(0, 63);
    return {$urandom, $urandom};
  endfunction

  // Absorb one accepted word into the predicted running hash; queue the
  // finalized hash when the word closes a message.
  task automatic absorb_word(input logic [MMH_WORD_W-1:0] word,
                             input logic [MMH_COUNT_BITS-1:0] count,
                             input logic first, input logic last);
    logic [MMH_WORD_W-1:0] scrambled;
    logic [MMH_WORD_W-1:0] final_hash;
    if (first) begin
      running_hash_model = seed_model ^
        ((MMH_WORD_W'(count) << MMH_BYTE_SHIFT) * MMH_MIX_MUL);
    end
    scrambled = word * MMH_MIX_MUL;
    scrambled = scrambled ^ (scrambled >> MMH_MIX_SHIFT);
    scrambled = scrambled * MMH_MIX_MUL;
    running_hash_model = (running_hash_model ^ scrambled) * MMH_MIX_MUL;
    if (last) begin
      final_hash = running_hash_model ^ (running_hash_model >> MMH_MIX_SHIFT);
      final_hash = final_hash * MMH_MIX_MUL;
      final_hash = final_hash ^ (final_hash >> MMH_MIX_SHIFT);
      expected_hashes.push_back(final_hash);
    end
  endtask

  // Monitor: all values here are the ones present before the edge, so a
  // handshake seen here is exactly the one the block took.
  always @(posedge clk) begin
    if (rst_n) begin
      // check results first: a word accepted now cannot produce one this edge
      if (out_valid && !out_stall) begin
        if (expected_hashes.size() == 0) begin
          $error("hash_value: expected none, actual %h", out_hash_value);
          mismatch_count++;
        end else begin
          oldest_hash = expected_hashes.pop_front();
          if (out_hash_value !== oldest_hash) begin
            $error("hash_value: expected %h, actual %h", oldest_hash, out_hash_value);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) seed_model = cfg_hash_seed;
      if (in_valid && !in_stall) begin
        absorb_word(in_data_word, in_message_words, in_first_word, in_last_word);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!out_quiet && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run if no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("murmur64a_word_hash regression: fail");
      $finish;
    end
  end

  // Offer one word request and hold it until taken. Valid stays high when
  // no gap follows, so back-to-back requests need no second assignment.
  task automatic send_word(input logic [MMH_WORD_W-1:0] word,
                           input logic [MMH_COUNT_BITS-1:0] count,
                           input logic first, input logic last);
    int unsigned gap;
    in_data_word     <= word;
    in_message_words <= count;
    in_first_word    <= first;
    in_last_word     <= last;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    gap = in_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, advance one edge so the monitor has queued the last
  // request, wait for every queued hash, then let a trailing word without
  // a last mark finish inside the block.
  task automatic drain_hashes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the seed register; call only with the block drained.
  task automatic write_seed(input logic [MMH_WORD_W-1:0] seed);
    cfg_hash_seed <= seed;
    cfg_valid     <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Right after reset the running hash is zero: a word without a first
  // mark must be mixed into zero, not into the seed.
  task automatic test_unmarked_after_reset();
    send_word(64'h0123_4567_89ab_cdef, 16'd3, 1'b0, 1'b1);
    drain_hashes();
  endtask

  // One-word messages with the reset seed: field extremes and a zero count,
  // where the hash starts at the bare seed.
  task automatic test_one_word_messages();
    send_word('0, 16'd1, 1'b1, 1'b1);
    send_word('1, 16'hffff, 1'b1, 1'b1);
    send_word(64'h0000_0000_0000_0001, 16'd0, 1'b1, 1'b1);
    send_word(64'h8000_0000_0000_0000, 16'd1, 1'b1, 1'b1);
    send_word(64'h5555_aaaa_5555_aaaa, 16'haaaa, 1'b1, 1'b1);
    drain_hashes();
  endtask

  // Longer messages: matching count, wrong count, zero count, and a word
  // without a first mark that extends the message just finished.
  task automatic test_multi_word_messages();
    send_word(64'h1111_2222_3333_4444, 16'd3, 1'b1, 1'b0);
    send_word(64'hdead_beef_cafe_f00d, 16'hffff, 1'b0, 1'b0);
    send_word(64'hffff_0000_ffff_0000, 16'h5555, 1'b0, 1'b1);
    send_word(64'h0f0f_0f0f_0f0f_0f0f, 16'd5, 1'b1, 1'b0);
    send_word(64'hf0f0_f0f0_f0f0_f0f0, 16'd0, 1'b0, 1'b1);
    send_word('1, 16'd0, 1'b1, 1'b0);
    send_word('0, 16'd2, 1'b0, 1'b1);
    send_word(64'h7fff_ffff_ffff_ffff, 16'd9, 1'b0, 1'b1);
    drain_hashes();
  endtask

  // Seed extremes: all zeros and all ones.
  task automatic test_seed_extremes();
    write_seed('0);
    send_word('0, 16'd0, 1'b1, 1'b1);
    send_word(64'h0000_0000_0000_00ff, 16'd1, 1'b1, 1'b1);
    drain_hashes();
    write_seed('1);
    send_word('0, 16'd0, 1'b1, 1'b1);
    send_word('1, 16'hffff, 1'b1, 1'b1);
    drain_hashes();
  endtask

  // Hold the result side off for a long stretch while the sender keeps
  // offering one-word messages back to back: the block must fill up and
  // stall its input, then recover without losing a hash.
  task automatic test_result_backpressure();
    in_quiet = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_word(pick_word(), 16'($urandom), 1'b1, 1'b1);
    end
    in_quiet = 1'b0;
    drain_hashes();
  endtask

  // Random traffic in four seed phases. Most requests form well-shaped
  // messages with random content; the rest are loose words with random
  // marks, which also break messages apart. One phase runs without gaps.
  task automatic test_random_traffic();
    logic [MMH_WORD_W-1:0]     phase_seed;
    logic [MMH_COUNT_BITS-1:0] count;
    int unsigned               sent;
    int unsigned               len;
    int unsigned               roll;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: begin
          phase_seed = 64'h8000_0000_0000_0001;
        end
        3: begin
          phase_seed = MMH_SEED_RESET;
        end
        default: begin
          phase_seed = {$urandom, $urandom};
        end
      endcase
      drain_hashes();
      write_seed(phase_seed);
      in_quiet  = (phase == 2);
      out_quiet = (phase == 2);
      sent = 0;
      while (sent < RANDOM_ITEMS / 4) begin
        if ($urandom_range(0, 99) < 85) begin
          roll = $urandom_range(0, 99);
          if (roll < 70) len = $urandom_range(1, 3);
          else if (roll < 95) len = $urandom_range(4, 8);
          else len = $urandom_range(9, 16);
          count = ($urandom_range(0, 4) == 0) ? MMH_COUNT_BITS'($urandom)
                                              : MMH_COUNT_BITS'(len);
          for (int w = 0; w < len; w++) begin
            send_word(pick_word(), (w == 0) ? count : MMH_COUNT_BITS'($urandom),
                      w == 0, w == len - 1);
          end
          sent += len;
        end else begin
          send_word(pick_word(), MMH_COUNT_BITS'($urandom), 1'($urandom), 1'($urandom));
          sent++;
        end
      end
    end
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    drain_hashes();
  endtask

  initial begin
    // hold reset, then release it on an edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_unmarked_after_reset();
    test_one_word_messages();
    test_multi_word_messages();
    test_seed_extremes();
    test_result_backpressure();
    test_random_traffic();

    // every hash is in; give the block time to show any stray result
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_hashes.size() == 0) begin
      $display("murmur64a_word_hash regression: pass");
    end else begin
      $display("murmur64a_word_hash regression: fail");
    end
    $finish;
  end

endmodule

/* murmur64a_word_hash.f */
rtl/mmh_pkg.sv
rtl/murmur64a_word_hash.sv
rtl/mmh_checker.sv
bench/murmur64a_word_hash_test.sv
